[hdl/gnms_pkg.sv]
// Shared types and constants for the gradient non-maximum suppression block.
package gnms_pkg;

    localparam int MAG_W      = 15;
    localparam int GRAD_W     = 11;
    localparam int DIR_W      = 2;
    localparam int FW_W       = 11;
    localparam int FH_W       = 16;
    localparam int CFG_DATA_W = 16;

    // Stream packing
    localparam int IN_GX_LSB   = MAG_W;
    localparam int IN_GY_LSB   = MAG_W + GRAD_W;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 11'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 16'd480;

    // Front-to-back queue depth, power of two
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_index;

    typedef enum logic [DIR_W-1:0] {
        DIR_HORIZONTAL    = 2'd0,
        DIR_DIAGONAL      = 2'd1,
        DIR_VERTICAL      = 2'd2,
        DIR_ANTI_DIAGONAL = 2'd3
    } t_dir;

    typedef struct packed {
        logic             drain;
        t_dir             dir;
        logic [MAG_W-1:0] mag;
    } t_item;

    typedef struct packed {
        logic [FW_W-1:0] frame_width;
        logic [FH_W-1:0] frame_height;
    } t_cfg;

endpackage

[hdl/gnms_front.sv]
// Front end: takes a pixel request and bins its gradient direction.
module gnms_front (
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [gnms_pkg::MAG_W-1:0]         i_mag,
    input  logic signed [gnms_pkg::GRAD_W-1:0] i_grad_x,
    input  logic signed [gnms_pkg::GRAD_W-1:0] i_grad_y,
    input  logic                               i_drain,
    output logic                               o_push,
    output gnms_pkg::t_item                    o_item,
    input  logic                               i_queue_ready
);
    import gnms_pkg::*;

    logic [GRAD_W-1:0]   abs_x;
    logic [GRAD_W-1:0]   abs_y;
    logic [GRAD_W:0]     sum_xy;
    logic [GRAD_W-1:0]   diff_yx;
    logic [2*GRAD_W-1:0] sq_x;
    logic [2*GRAD_W:0]   twice_x2;
    logic [2*GRAD_W+1:0] sum_sq;
    logic [2*GRAD_W-1:0] diff_sq;
    t_dir                bin;

    assign abs_x    = i_grad_x[GRAD_W-1] ? $unsigned(-i_grad_x) : $unsigned(i_grad_x);
    assign abs_y    = i_grad_y[GRAD_W-1] ? $unsigned(-i_grad_y) : $unsigned(i_grad_y);
    assign sum_xy   = {1'b0, abs_x} + {1'b0, abs_y};
    assign diff_yx  = abs_y - abs_x;
    assign sq_x     = abs_x * abs_x;
    assign twice_x2 = {sq_x, 1'b0};
    assign sum_sq   = sum_xy * sum_xy;
    assign diff_sq  = diff_yx * diff_yx;

    // tan(22.5) = sqrt2-1 and tan(67.5) = sqrt2+1 compared through exact squares
    always_comb begin
        priority if (abs_x == '0 || abs_y == '0) begin
            bin = DIR_HORIZONTAL;
        end else if (sum_sq <= {1'b0, twice_x2}) begin
            bin = DIR_HORIZONTAL;
        end else if (abs_y > abs_x && {1'b0, diff_sq} > twice_x2) begin
            bin = DIR_VERTICAL;
        end else if (i_grad_x[GRAD_W-1] == i_grad_y[GRAD_W-1]) begin
            bin = DIR_DIAGONAL;
        end else begin
            bin = DIR_ANTI_DIAGONAL;
        end
    end

    assign o_item.drain = i_drain;
    assign o_item.dir   = i_drain ? DIR_HORIZONTAL : bin;
    assign o_item.mag   = i_drain ? '0 : i_mag;
    assign o_push       = i_in_valid && i_queue_ready;
    assign o_in_ready   = i_queue_ready;

endmodule

[hdl/gnms_queue.sv]
// Short FIFO between the classifying front end and the suppression back end.
module gnms_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gnms_pkg::t_item i_item,
    output logic            o_ready,
    output logic            o_valid,
    output gnms_pkg::t_item o_item,
    input  logic            i_pop
);
    import gnms_pkg::*;

    localparam int PW    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_slot [QUEUE_DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_ready = r_count != CNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr_ptr] <= i_item;
    end

endmodule

[hdl/gnms_back.sv]
// Back end: line buffers, neighbor compare and result register.
module gnms_back #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gnms_pkg::t_cfg               i_cfg,
    input  logic [gnms_pkg::FW_W-1:0]    i_next_frame_width,
    input  logic                         i_q_valid,
    input  gnms_pkg::t_item              i_q_item,
    output logic                         o_q_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [gnms_pkg::MAG_W-1:0]   o_out_mag,
    output gnms_pkg::t_dir               o_out_dir,
    output logic                         o_out_last
);
    import gnms_pkg::*;

    localparam int RING = MAX_WIDTH + 2;
    localparam int AW   = $clog2(RING);
    localparam int WW   = $clog2(MAX_WIDTH + 2);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam logic [WW-1:0] FILL_MAX = WW'(MAX_WIDTH + 1);

    function automatic logic [WW-1:0] eff_width(input logic [FW_W-1:0] fw);
        int unsigned fw_i;
        fw_i = 32'(fw);
        if (fw_i < 32'd2) return WW'(2);
        else if (fw_i > 32'(MAX_WIDTH)) return WW'(MAX_WIDTH);
        else return WW'(fw_i);
    endfunction

    function automatic logic [AW-1:0] lag_addr(input logic [AW-1:0] pos,
                                               input logic [WW-1:0] lag);
        logic [AW:0] sum;
        sum = {1'b0, pos} + (AW+1)'(RING) - (AW+1)'(lag);
        if (sum >= (AW+1)'(RING)) sum = sum - (AW+1)'(RING);
        return sum[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] pos);
        return (pos == AW'(RING - 1)) ? '0 : pos + 1'b1;
    endfunction

    logic [WW-1:0]    w_cur;
    logic [WW-1:0]    w_next;
    logic [FH_W-1:0]  h_cur;

    t_item            r_item_mem [RING];
    logic [MAG_W-1:0] r_sup_mem_a [RING];
    logic [MAG_W-1:0] r_sup_mem_b [RING];

    t_item            r_tap_w;
    t_item            r_tap_c;
    logic [MAG_W-1:0] r_sup_ul;
    logic [MAG_W-1:0] r_sup_u;
    logic [MAG_W-1:0] r_sup_ur;
    logic [MAG_W-1:0] r_lag1_mag;
    logic [MAG_W-1:0] r_lag2_mag;
    logic [MAG_W-1:0] r_left;

    logic [AW-1:0]    r_item_pos;
    logic [AW-1:0]    n_item_pos;
    logic [AW-1:0]    r_result_pos;
    logic [AW-1:0]    n_result_pos;
    logic [WW-1:0]    r_fill;
    logic [CW-1:0]    r_col;
    logic [FH_W-1:0]  r_row;

    logic             r_out_valid;
    logic [MAG_W-1:0] r_out_mag;
    t_dir             r_out_dir;
    logic             r_out_last;

    logic [AW-1:0]    rd_w;
    logic [AW-1:0]    rd_c;
    logic [AW-1:0]    rd_ul;
    logic [AW-1:0]    rd_u;
    logic [AW-1:0]    rd_ur;

    logic             step;
    logic             centre_ok;
    logic             produce;
    logic             col_last;
    logic             row_last;
    logic             top;
    logic             bottom;
    logic             left;
    logic             right;
    logic             kill;
    logic [MAG_W-1:0] m0;
    logic [MAG_W-1:0] res;

    assign w_cur  = eff_width(i_cfg.frame_width);
    assign w_next = eff_width(i_next_frame_width);
    assign h_cur  = (i_cfg.frame_height == '0) ? FH_W'(1) : i_cfg.frame_height;

    assign step      = i_q_valid && (!r_out_valid || i_out_ready);
    // centre sits w+1 items back; fill count stands in for per-entry valid bits
    assign centre_ok = (r_fill >= WW'(w_cur + 1'b1)) && !r_tap_c.drain;
    assign produce   = step && centre_ok;

    assign col_last = WW'(WW'(r_col) + 1'b1) >= w_cur;
    assign row_last = ({1'b0, r_row} + 1'b1) >= {1'b0, h_cur};
    assign top      = r_row != '0;
    assign bottom   = !row_last;
    assign left     = r_col != '0;
    assign right    = !col_last;

    assign m0 = r_tap_c.mag;

    // above and left come from suppressed results, below and right are raw
    always_comb begin
        unique case (r_tap_c.dir)
            DIR_HORIZONTAL:
                kill = (left && m0 <= r_left) || (right && m0 <= r_tap_w.mag);
            DIR_DIAGONAL:
                kill = (top && left && m0 <= r_sup_ul) ||
                       (bottom && right && m0 <= i_q_item.mag);
            DIR_VERTICAL:
                kill = (top && m0 <= r_sup_u) || (bottom && m0 <= r_lag1_mag);
            DIR_ANTI_DIAGONAL:
                kill = (top && right && m0 <= r_sup_ur) ||
                       (bottom && left && m0 <= r_lag2_mag);
            default:
                kill = 1'b0;
        endcase
    end

    assign res = kill ? '0 : m0;

    assign n_item_pos   = step ? next_pos(r_item_pos) : r_item_pos;
    assign n_result_pos = produce ? next_pos(r_result_pos) : r_result_pos;

    // read ahead for the next step, using the width that will then apply
    assign rd_w  = lag_addr(n_item_pos, w_next);
    assign rd_c  = lag_addr(n_item_pos, WW'(w_next + 1'b1));
    assign rd_ul = lag_addr(n_result_pos, WW'(w_next + 1'b1));
    assign rd_u  = lag_addr(n_result_pos, w_next);
    assign rd_ur = lag_addr(n_result_pos, WW'(w_next - 1'b1));

    always_ff @(posedge i_clk) begin
        if (step) r_item_mem[r_item_pos] <= i_q_item;
        r_tap_w <= r_item_mem[rd_w];
        r_tap_c <= r_item_mem[rd_c];
    end

    always_ff @(posedge i_clk) begin
        if (produce) r_sup_mem_a[r_result_pos] <= res;
        r_sup_ul <= r_sup_mem_a[rd_ul];
        r_sup_u  <= r_sup_mem_a[rd_u];
    end

    // up-right equals the left neighbor at width 2: forward the write
    always_ff @(posedge i_clk) begin
        if (produce) r_sup_mem_b[r_result_pos] <= res;
        if (produce && rd_ur == r_result_pos) begin
            r_sup_ur <= res;
        end else begin
            r_sup_ur <= r_sup_mem_b[rd_ur];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_pos   <= '0;
            r_result_pos <= '0;
            r_fill       <= '0;
            r_col        <= '0;
            r_row        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_item_pos   <= n_item_pos;
            r_result_pos <= n_result_pos;
            if (step && r_fill != FILL_MAX) r_fill <= r_fill + 1'b1;
            if (produce) begin
                if (col_last) begin
                    r_col <= '0;
                    r_row <= row_last ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (step) begin
                r_out_valid <= centre_ok;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_lag2_mag <= r_lag1_mag;
            r_lag1_mag <= i_q_item.mag;
        end
        if (produce) begin
            r_left     <= res;
            r_out_mag  <= res;
            r_out_dir  <= r_tap_c.dir;
            r_out_last <= col_last && row_last;
        end
    end

    assign o_q_pop     = step;
    assign o_out_valid = r_out_valid;
    assign o_out_mag   = r_out_mag;
    assign o_out_dir   = r_out_dir;
    assign o_out_last  = r_out_last;

endmodule

[hdl/gradient_non_maximum_suppression.sv]
// Top level of the gradient non-maximum suppression block.
//
// Streams raster pixels (gradient magnitude, Sobel x/y) and returns each pixel's
// magnitude, zeroed when a neighbor along its binned gradient direction is greater
// or equal, plus the direction bin and an end-of-frame flag on tlast. Sustained
// rate is one pixel per clock while the output does not stall: the back end reads
// items via two read ports and results via three, with addresses fetched one
// request ahead. A pixel's result leaves frame_width+1 input requests after the
// pixel itself, so the source must send frame_width+1 drain requests (tuser high)
// after each frame to flush it; the first frame_width+1 requests after reset give
// no result. Beyond that lag, results pass the queue and the output register.
// There is no clearing pass after reset. Write frame_width and frame_height only
// between frames, with the block idle; widths are held to 2..MAX_WIDTH and a
// height of zero acts as one.
module gradient_non_maximum_suppression #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // magnitude[14:0], grad_x[25:15], grad_y[36:26], zero[39:37]
    input  logic [gnms_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // is_drain[0]
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // suppressed_magnitude[14:0], direction_bin[16:15], zero[23:17]
    output logic [gnms_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast,
    input  logic                                i_cfg_we,
    input  logic [0:0]                          i_cfg_index,
    input  logic [gnms_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import gnms_pkg::*;

    t_cfg             r_cfg;
    t_cfg             n_cfg;

    logic             push;
    logic             q_ready;
    t_item            front_item;
    logic             q_valid;
    t_item            q_item;
    logic             q_pop;
    logic [MAG_W-1:0] out_mag;
    t_dir             out_dir;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_FRAME_WIDTH:  n_cfg.frame_width  = i_cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: n_cfg.frame_height = i_cfg_data[FH_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width  <= FRAME_WIDTH_RESET;
            r_cfg.frame_height <= FRAME_HEIGHT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    gnms_front u_front (
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_mag         (s_axis_tdata[MAG_W-1:0]),
        .i_grad_x      ($signed(s_axis_tdata[IN_GX_LSB +: GRAD_W])),
        .i_grad_y      ($signed(s_axis_tdata[IN_GY_LSB +: GRAD_W])),
        .i_drain       (s_axis_tuser),
        .o_push        (push),
        .o_item        (front_item),
        .i_queue_ready (q_ready)
    );

    gnms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    gnms_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_next_frame_width (n_cfg.frame_width),
        .i_q_valid          (q_valid),
        .i_q_item           (q_item),
        .o_q_pop            (q_pop),
        .o_out_valid        (m_axis_tvalid),
        .i_out_ready        (m_axis_tready),
        .o_out_mag          (out_mag),
        .o_out_dir          (out_dir),
        .o_out_last         (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_TDATA_W'({out_dir, out_mag});

endmodule

[hdl/gnms_checker.sv]
// Port-level checks for the gradient non-maximum suppression block, with its bind.
module gnms_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [gnms_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             m_axis_tlast
);

    logic [31:0] r_in_count;
    logic [31:0] r_out_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_count  <= '0;
            r_out_count <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) r_in_count  <= r_in_count + 1'b1;
            if (m_axis_tvalid && m_axis_tready) r_out_count <= r_out_count + 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("result changed while stalled");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (s_axis_tready && !m_axis_tvalid))
        else $error("not empty and ready after reset");

    // each result belongs to a pixel that entered earlier
    a_no_extra_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready) |-> (r_out_count < r_in_count))
        else $error("more results than requests taken");

endmodule

bind gradient_non_maximum_suppression gnms_checker u_gnms_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

[tb/gradient_non_maximum_suppression_tb.sv]
// Self-checking testbench for the gradient non-maximum suppression block.
`timescale 1ns / 1ps

module gradient_non_maximum_suppression_tb;
    import gnms_pkg::*;

    localparam int MAX_W        = 1024;
    localparam int RING         = MAX_W + 2;
    localparam int RAND_PIXELS  = 1550;
    localparam int DRAIN_PAD    = 8;
    localparam int LIMIT_CYCLES = 4_000_000;

    typedef enum {ROW_CFG, ROW_PIXEL, ROW_DRAIN} t_row_kind;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        t_dir             dir;
        logic             last;
    } t_pixel_result;

    typedef struct {
        t_row_kind          kind;
        t_cfg_index         sel;
        logic [15:0]        value;
        logic [MAG_W-1:0]   mag;
        logic [GRAD_W-1:0]  gx;
        logic [GRAD_W-1:0]  gy;
        bit                 typed;
        t_pixel_result      want;
    } t_step;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // magnitude[14:0], grad_x[25:15], grad_y[36:26], zero[39:37]
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // is_drain[0]
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // suppressed_magnitude[14:0], direction_bin[16:15], zero[23:17]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   i_cfg_we = 1'b0;
    logic [0:0]             i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    gradient_non_maximum_suppression #(
        .MAX_WIDTH(MAX_W)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Shadow of the block: delay line of requests, ring of suppressed results
    logic [MAG_W-1:0] raw_line  [RING];
    t_dir             dir_line  [RING];
    bit               valid_line[RING];
    logic [MAG_W-1:0] supp_line [RING];
    int unsigned      wr_pos, res_pos, out_col, out_row;
    logic [FW_W-1:0]  cfg_w = FRAME_WIDTH_RESET;
    logic [FH_W-1:0]  cfg_h = FRAME_HEIGHT_RESET;

    t_pixel_result pending_pixels[$];
    int            pixel_row_tags[$];
    t_step         steps[$];

    int unsigned cycles = 0;
    int          err_count = 0;
    int          results_checked = 0;
    int          pixels_sent = 0;
    int          drains_sent = 0;
    int          frames_sent = 0;
    int          reg_writes = 0;
    int          tx_mode = 0;
    int          rx_mode = 0;
    int          rx_hold = 0;

    function automatic int unsigned eff_width();
        return (cfg_w < 2) ? 2 : ((cfg_w > MAX_W) ? MAX_W : int'(cfg_w));
    endfunction

    function automatic int unsigned eff_height();
        return (cfg_h < 1) ? 1 : int'(cfg_h);
    endfunction

    function automatic int unsigned ring_back(input int unsigned pos, input int unsigned lag);
        return (pos + RING - (lag % RING)) % RING;
    endfunction

    // Exact binning against tan(22.5) = sqrt2-1 and tan(67.5) = sqrt2+1
    function automatic t_dir grad_bin(input int gx, input int gy);
        longint a, b, twice_a2;
        a = (gx < 0) ? -gx : gx;
        b = (gy < 0) ? -gy : gy;
        if (a == 0 || b == 0)
            return DIR_HORIZONTAL;
        twice_a2 = 2 * a * a;
        if ((a + b) * (a + b) <= twice_a2)
            return DIR_HORIZONTAL;
        if (b > a && (b - a) * (b - a) > twice_a2)
            return DIR_VERTICAL;
        return ((gx < 0) == (gy < 0)) ? DIR_DIAGONAL : DIR_ANTI_DIAGONAL;
    endfunction

    function automatic bit predict_suppression(input logic [MAG_W-1:0] mag,
                                               input logic [GRAD_W-1:0] gx,
                                               input logic [GRAD_W-1:0] gy,
                                               input bit drain,
                                               output t_pixel_result res);
        int unsigned w, h, centre, r, c;
        logic [MAG_W-1:0] m0;
        t_dir d;
        bit top, bottom, left, right, kill;
        w = eff_width();
        h = eff_height();
        res = '0;
        valid_line[wr_pos] = !drain;
        raw_line[wr_pos]   = drain ? '0 : mag;
        dir_line[wr_pos]   = drain ? DIR_HORIZONTAL : grad_bin($signed(gx), $signed(gy));
        centre = ring_back(wr_pos, w + 1);
        if (!valid_line[centre]) begin
            wr_pos = (wr_pos + 1) % RING;
            return 1'b0;
        end
        m0     = raw_line[centre];
        d      = dir_line[centre];
        r      = out_row;
        c      = out_col;
        top    = r > 0;
        bottom = r + 1 < h;
        left   = c > 0;
        right  = c + 1 < w;
        kill   = 1'b0;
        // upper and left neighbors are already suppressed, the rest are raw
        case (d)
            DIR_HORIZONTAL: begin
                if (left && m0 <= supp_line[ring_back(res_pos, 1)]) kill = 1'b1;
                if (right && m0 <= raw_line[ring_back(wr_pos, w)]) kill = 1'b1;
            end
            DIR_DIAGONAL: begin
                if (top && left && m0 <= supp_line[ring_back(res_pos, w + 1)]) kill = 1'b1;
                if (bottom && right && m0 <= raw_line[wr_pos]) kill = 1'b1;
            end
            DIR_VERTICAL: begin
                if (top && m0 <= supp_line[ring_back(res_pos, w)]) kill = 1'b1;
                if (bottom && m0 <= raw_line[ring_back(wr_pos, 1)]) kill = 1'b1;
            end
            default: begin
                if (top && right && m0 <= supp_line[ring_back(res_pos, w - 1)]) kill = 1'b1;
                if (bottom && left && m0 <= raw_line[ring_back(wr_pos, 2)]) kill = 1'b1;
            end
        endcase
        res.mag  = kill ? '0 : m0;
        res.dir  = d;
        res.last = (c + 1 >= w) && (r + 1 >= h);
        supp_line[res_pos] = res.mag;
        res_pos = (res_pos + 1) % RING;
        wr_pos  = (wr_pos + 1) % RING;
        if (c + 1 >= w) begin
            out_col = 0;
            out_row = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            out_col = c + 1;
        end
        return 1'b1;
    endfunction

    function automatic int unsigned gap_len(input int mode);
        int roll;
        roll = $urandom_range(0, 99);
        if (mode == 0)
            return 0;
        if (roll < ((mode == 1) ? 80 : 40))
            return 0;
        if (roll < 97)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [GRAD_W-1:0] rand_grad();
        int roll, v;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return GRAD_W'($urandom_range(0, 2047));
        if (roll < 4)
            v = int'($urandom_range(0, 16)) - 8;
        else
            v = int'($urandom_range(0, 2040)) - 1020;
        return v[GRAD_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
        err_count++;
    endtask

    task automatic send_request(input logic [MAG_W-1:0] mag, input logic [GRAD_W-1:0] gx,
                                input logic [GRAD_W-1:0] gy, input bit drain, input int tag);
        int unsigned gap;
        t_pixel_result res;
        int row;
        gap = gap_len(tx_mode);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, gy, gx, mag};
        s_axis_tuser  <= drain;
        do @(posedge i_clk); while (!s_axis_tready);
        if (drain) begin
            drains_sent++;
        end else begin
            pixels_sent++;
            pixel_row_tags.push_back(tag);
        end
        if (predict_suppression(mag, gx, gy, drain, res)) begin
            row = pixel_row_tags.pop_front();
            if (row >= 0 && steps[row].typed)
                res = steps[row].want;
            pending_pixels.push_back(res);
        end
    endtask

    task automatic send_random_pixel();
        logic [MAG_W-1:0] mag;
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            mag = '0;
        else if (roll == 1)
            mag = '1;
        else if (roll < 6)
            mag = MAG_W'($urandom_range(0, 15));   // ties are frequent
        else
            mag = MAG_W'($urandom_range(0, 32767));
        send_request(mag, rand_grad(), rand_grad(), 1'b0, -1);
    endtask

    task automatic send_random_drains(input int unsigned n);
        repeat (n) send_request(MAG_W'($urandom), rand_grad(), rand_grad(), 1'b1, -1);
    endtask

    // Wait for every predicted result, then let the tail of the pipe settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index sel, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (sel == CFG_FRAME_WIDTH)
            cfg_w = value[FW_W-1:0];
        else
            cfg_h = value[FH_W-1:0];
        reg_writes++;
        @(posedge i_clk);
    endtask

    task automatic send_random_frame(input bit with_inner_drains);
        int unsigned n;
        n = eff_width() * eff_height();
        for (int unsigned p = 0; p < n; p++) begin
            if (with_inner_drains && $urandom_range(0, 99) < 3)
                send_random_drains(1);
            send_random_pixel();
        end
        frames_sent++;
    endtask

    // Receiver: always ready in mode 0, else stalls of random length, mostly short
    always @(posedge i_clk) begin
        int roll;
        roll = $urandom_range(0, 99);
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else if (rx_mode == 0) begin
            m_axis_tready <= 1'b1;
        end else if (roll < ((rx_mode == 1) ? 85 : 55)) begin
            m_axis_tready <= 1'b1;
            rx_hold <= $urandom_range(0, 6);
        end else if (roll < 97) begin
            m_axis_tready <= 1'b0;
            rx_hold <= $urandom_range(0, 3);
        end else begin
            m_axis_tready <= 1'b0;
            rx_hold <= $urandom_range(10, 40);
        end
    end

    always @(posedge i_clk) begin
        t_pixel_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("result with nothing expected, magnitude",
                                int'(m_axis_tdata[MAG_W-1:0]), -1);
            end else begin
                want = pending_pixels.pop_front();
                results_checked++;
                if (m_axis_tdata[MAG_W-1:0] !== want.mag)
                    report_mismatch("suppressed_magnitude", int'(m_axis_tdata[MAG_W-1:0]),
                                    int'(want.mag));
                if (m_axis_tdata[MAG_W +: DIR_W] !== want.dir)
                    report_mismatch("direction_bin", int'(m_axis_tdata[MAG_W +: DIR_W]),
                                    int'(want.dir));
                if (m_axis_tlast !== want.last)
                    report_mismatch("last_of_frame", int'(m_axis_tlast), int'(want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_pixels.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        bit carry;
        int unsigned n, w_data;
        int frame_idx;

        // Single-row 2-wide frame: both results follow directly from the inputs
        steps.push_back('{ROW_CFG, CFG_FRAME_WIDTH, 16'd0, '0, '0, '0, 1'b0, '0});
        steps.push_back('{ROW_CFG, CFG_FRAME_HEIGHT, 16'd0, '0, '0, '0, 1'b0, '0});
        steps.push_back('{ROW_PIXEL, CFG_FRAME_WIDTH, '0, 15'h7fff, 11'd0, 11'd0, 1'b1,
                          '{15'h7fff, DIR_HORIZONTAL, 1'b0}});
        steps.push_back('{ROW_PIXEL, CFG_FRAME_WIDTH, '0, 15'd0, 11'd1020, 11'd1020, 1'b1,
                          '{15'd0, DIR_DIAGONAL, 1'b1}});
        steps.push_back('{ROW_DRAIN, CFG_FRAME_WIDTH, '0, 15'h7fff, 11'h400, 11'h3ff, 1'b0, '0});
        steps.push_back('{ROW_DRAIN, CFG_FRAME_WIDTH, '0, '0, '0, '0, 1'b0, '0});
        steps.push_back('{ROW_DRAIN, CFG_FRAME_WIDTH, '0, '0, '0, '0, 1'b0, '0});
        // 3x2 frames: bin boundaries, extremes, ties; first frame short of drains
        steps.push_back('{ROW_CFG, CFG_FRAME_WIDTH, 16'd3, '0, '0, '0, 1'b0, '0});
        steps.push_back('{ROW_CFG, CFG_FRAME_HEIGHT, 16'd2, '0, '0, '0, 1'b0, '0});
        steps.push_back('{ROW_PIXEL, CFG_FRAME_WIDTH, '0, 15'd100, 11'd5, 11'd2, 1'b0, '0});
        steps.push_back('{ROW_PIXEL, CFG_FRAME_WIDTH, '0, 15'd100, 11'd5, 11'd3, 1'b0, '0});
        steps.push_back('{ROW_PIXEL, CFG_FRAME_WIDTH, '0, 15'd7, 11'h400, 11'h400, 1'b0, '0});
        steps.push_back('{ROW_PIXEL, CFG_FRAME_WIDTH, '0, 15'd200, 11'd2, 11'd5, 1'b0, '0});
        steps.push_back('{ROW_PIXEL, CFG_FRAME_WIDTH, '0, 15'd200, 11'd3, 11'd7, 1'b0, '0});
        steps.push_back('{ROW_PIXEL, CFG_FRAME_WIDTH, '0, 15'd0, -11'sd10, 11'd10, 1'b0, '0});
        steps.push_back('{ROW_DRAIN, CFG_FRAME_WIDTH, '0, '0, '0, '0, 1'b0, '0});
        steps.push_back('{ROW_PIXEL, CFG_FRAME_WIDTH, '0, 15'd500, 11'd0, 11'd9, 1'b0, '0});
        steps.push_back('{ROW_PIXEL, CFG_FRAME_WIDTH, '0, 15'd500, 11'd1023, 11'd0, 1'b0, '0});
        steps.push_back('{ROW_DRAIN, CFG_FRAME_WIDTH, '0, '0, '0, '0, 1'b0, '0});
        steps.push_back('{ROW_PIXEL, CFG_FRAME_WIDTH, '0, 15'd300, 11'd1020, -11'sd1020,
                          1'b0, '0});
        steps.push_back('{ROW_PIXEL, CFG_FRAME_WIDTH, '0, 15'h7fff, 11'd1, 11'd1020, 1'b0, '0});
        steps.push_back('{ROW_PIXEL, CFG_FRAME_WIDTH, '0, 15'd300, -11'sd1020, 11'd1020,
                          1'b0, '0});
        steps.push_back('{ROW_PIXEL, CFG_FRAME_WIDTH, '0, 15'd1, -11'sd1020, -11'sd1, 1'b0, '0});
        repeat (4) steps.push_back('{ROW_DRAIN, CFG_FRAME_WIDTH, '0, '0, '0, '0, 1'b0, '0});

        wr_pos  = 0;
        res_pos = 0;
        out_col = 0;
        out_row = 0;
        foreach (valid_line[i]) begin
            valid_line[i] = 1'b0;
            raw_line[i]   = '0;
            dir_line[i]   = DIR_HORIZONTAL;
            supp_line[i]  = '0;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (steps[i]) begin
            case (steps[i].kind)
                ROW_CFG: begin
                    wait_drained();
                    write_reg(steps[i].sel, steps[i].value);
                end
                ROW_PIXEL: send_request(steps[i].mag, steps[i].gx, steps[i].gy, 1'b0, i);
                default:   send_request(steps[i].mag, steps[i].gx, steps[i].gy, 1'b1, i);
            endcase
        end
        frames_sent += 3;

        // Random frames, small sizes; a frame short of drains keeps its size for the next one
        carry = 1'b0;
        frame_idx = 0;
        while (pixels_sent < RAND_PIXELS) begin
            if (!carry) begin
                wait_drained();
                case ($urandom_range(0, 19))
                    0:       w_data = $urandom_range(0, 1);
                    1:       w_data = 16'hf800 | $urandom_range(2, 12);  // upper bits unused
                    default: w_data = $urandom_range(2, 12);
                endcase
                write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w_data));
                write_reg(CFG_FRAME_HEIGHT,
                          ($urandom_range(0, 9) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 6)));
            end
            tx_mode = $urandom_range(0, 2);
            rx_mode <= $urandom_range(0, 2);
            if (frame_idx == 5) begin
                n = eff_width() * eff_height();
                for (int unsigned p = 0; p < n; p++) begin
                    if (p == n / 2)
                        wait_drained();
                    send_random_pixel();
                end
                frames_sent++;
            end else begin
                send_random_frame(1'b1);
            end
            if ($urandom_range(0, 99) < 15) begin
                send_random_drains($urandom_range(0, eff_width()));
                carry = 1'b1;
            end else begin
                send_random_drains(eff_width() + 1 + (($urandom_range(0, 9) == 0) ?
                                                      $urandom_range(1, 3) : 0));
                carry = 1'b0;
            end
            frame_idx++;
        end
        send_random_drains(eff_width() + 1);

        // Widest frames, exact and clamped width
        tx_mode = 1;
        rx_mode <= 1;
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, 16'd1024);
        write_reg(CFG_FRAME_HEIGHT, 16'd2);
        send_random_frame(1'b0);
        send_random_drains(eff_width() + 1);
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, 16'd2047);
        write_reg(CFG_FRAME_HEIGHT, 16'd0);
        send_random_frame(1'b0);
        send_random_drains(eff_width() + 1);

        // Tallest height: only the top of the frame is streamed
        tx_mode = 2;
        rx_mode <= 2;
        wait_drained();
        write_reg(CFG_FRAME_WIDTH, 16'd2);
        write_reg(CFG_FRAME_HEIGHT, 16'hffff);
        repeat (40) send_random_pixel();
        send_random_drains(eff_width() + 1);

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("Streamed %0d pixels and %0d drain requests in %0d frames, %0d register writes",
                 pixels_sent, drains_sent, frames_sent, reg_writes);
        $display("Checked %0d results, %0d mismatches", results_checked, err_count);
        if (err_count == 0 && pending_pixels.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
hdl/gnms_pkg.sv
hdl/gnms_front.sv
hdl/gnms_queue.sv
hdl/gnms_back.sv
hdl/gradient_non_maximum_suppression.sv
hdl/gnms_checker.sv
tb/gradient_non_maximum_suppression_tb.sv
